// ===== rtl/core/m3it_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3it_pkg
// Shared types and constants for the 3x3 inverse-transpose pipeline.
// ----------------------------------------------------------------------------
package m3it_pkg;

  localparam int ElemW   = 16;   // Q4.12 input element
  localparam int ResW    = 32;   // Q15.16 result element
  localparam int CofW    = 33;   // exact cofactor
  localparam int CmagW   = 32;   // cofactor magnitude
  localparam int DenW    = 48;   // determinant magnitude
  localparam int LowW    = 5;    // cofactor bits shifted in during division
  localparam int Steps   = 34;   // quotient bits of 2*|c|*2^28/|det|
  localparam int LaneLat = Steps + 2;
  localparam int FrontLat = 4;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SINGULAR = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [CmagW-1:0] c_mag;
    logic [DenW-1:0]  den;
    logic             neg;
    logic             zero;
  } lane_in_t;

  typedef struct packed {
    logic signed [ResW-1:0] res;
    logic                   sat;
    logic                   zero;
  } lane_out_t;

endpackage

// ===== rtl/core/m3it_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3it_in_if / m3it_out_if
// Valid/ready channels carrying a matrix in and its inverse-transpose out.
// ----------------------------------------------------------------------------
interface m3it_in_if;
  logic                   valid;
  logic                   ready;
  logic signed [15:0]     a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface m3it_out_if;
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     r00, r01, r02, r10, r11, r12, r20, r21, r22;
  m3it_pkg::status_t      status;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, status,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, status,
                  output ready);
endinterface

// ===== rtl/core/m3it_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3it_div_lane
// Pipelined restoring divider: rounded, saturated |c|*2^28/|det| with sign,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module m3it_div_lane (
  input  logic                 clk,
  input  logic                 en,
  input  m3it_pkg::lane_in_t   din,
  output m3it_pkg::lane_out_t  dout
);

  localparam int N  = m3it_pkg::Steps;
  localparam int DW = m3it_pkg::DenW;
  localparam int LW = m3it_pkg::LowW;

  logic [DW-1:0] rem  [N+1];
  logic [DW-1:0] den  [N+1];
  logic [N-1:0]  quo  [N+1];
  logic [LW-1:0] low  [N+1];
  logic          ovf  [N+1];
  logic          neg  [N+1];
  logic          zero [N+1];

  // entry: top dividend bits form the first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DW'(din.c_mag >> LW);
      ovf[0]  <= DW'(din.c_mag >> LW) >= din.den;
      low[0]  <= din.c_mag[LW-1:0];
      den[0]  <= din.den;
      quo[0]  <= '0;
      neg[0]  <= din.neg;
      zero[0] <= din.zero;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int Bit = N - 1 - k;
    logic          nb;
    logic [DW:0]   trial;
    logic          take;

    if (Bit >= N - LW) begin : g_low
      assign nb = low[k][Bit - (N - LW)];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {rem[k], nb};
    assign take  = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? DW'(trial - {1'b0, den[k]}) : trial[DW-1:0];
        quo[k+1]  <= {quo[k][N-2:0], take};
        den[k+1]  <= den[k];
        low[k+1]  <= low[k];
        ovf[k+1]  <= ovf[k];
        neg[k+1]  <= neg[k];
        zero[k+1] <= zero[k];
      end
    end
  end

  // round half away from zero, then saturate
  logic [N:0]  q_rnd;
  logic [N:0]  q_half;
  logic        sat_next;
  logic [31:0] res_next;

  always_comb begin
    q_rnd  = {1'b0, quo[N]} + (N+1)'(1);
    q_half = q_rnd >> 1;
    if (neg[N]) begin
      sat_next = ovf[N] || (q_half > (N+1)'(33'h1_0000_0000 >> 1));
      res_next = sat_next ? 32'h8000_0000 : 32'(-q_half);
    end else begin
      sat_next = ovf[N] || (q_half > (N+1)'(32'h7FFF_FFFF));
      res_next = sat_next ? 32'h7FFF_FFFF : q_half[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.res  <= zero[N] ? '0 : signed'(res_next);
      dout.sat  <= sat_next && !zero[N];
      dout.zero <= zero[N];
    end
  end

endmodule

// ===== rtl/core/matrix3_inverse_transpose.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_transpose
// Fixed-point 3x3 inverse-transpose: cofactors over determinant, Q15.16 out.
// ----------------------------------------------------------------------------
// Usage:
//   mat : one Q4.12 matrix per transaction, row-major a00..a22.
//   res : nine Q15.16 elements r00..r22 and a status code per transaction.
//         status OK, SINGULAR (zero determinant, all outputs zero) or
//         OVERFLOW (at least one element clipped to the Q15.16 range).
//   The pipeline has four front stages (products, cofactors,
//   determinant products, determinant sum) and 36 stages in each of
//   the nine divider lanes: entry, one per quotient bit, and output.
//   Throughput is one matrix per cycle while res is not stalled.
//   The whole pipeline advances together; while res is stalled with a
//   valid result, mat.ready is low and nothing moves. Bubbles are absorbed
//   whenever the output stage is empty.
//   Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module matrix3_inverse_transpose (
  input  logic         clk,
  input  logic         rst,
  m3it_in_if.sink      mat,
  m3it_out_if.source   res
);

  localparam int Lat = m3it_pkg::FrontLat + m3it_pkg::LaneLat;

  logic           en;
  logic [Lat-1:0] vld;

  assign en        = !vld[Lat-1] || res.ready;
  assign mat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], mat.valid};
    end
  end

  // stage 1: cofactor products
  logic signed [15:0] m   [9];
  logic signed [15:0] pa  [9], pb [9], pc [9], pd [9];
  logic signed [31:0] pp  [9], pm [9];
  logic signed [15:0] r1  [3];

  assign m = '{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12,
               mat.a20, mat.a21, mat.a22};

  assign pa = '{m[4], m[5], m[3], m[2], m[0], m[1], m[1], m[2], m[0]};
  assign pb = '{m[8], m[6], m[7], m[7], m[8], m[6], m[5], m[3], m[4]};
  assign pc = '{m[5], m[3], m[4], m[1], m[2], m[0], m[2], m[0], m[1]};
  assign pd = '{m[7], m[8], m[6], m[8], m[6], m[7], m[4], m[5], m[3]};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pp[k] <= 32'(pa[k]) * 32'(pb[k]);
        pm[k] <= 32'(pc[k]) * 32'(pd[k]);
      end
      r1 <= '{m[0], m[1], m[2]};
    end
  end

  // stage 2: cofactors
  logic signed [32:0] cof2 [9];
  logic signed [15:0] r2   [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        cof2[k] <= 33'(pp[k]) - 33'(pm[k]);
      end
      r2 <= r1;
    end
  end

  // stage 3: determinant products
  logic signed [32:0] cof3 [9];
  logic signed [48:0] dp   [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dp[j] <= 49'(r2[j]) * 49'(cof2[j]);
      end
      cof3 <= cof2;
    end
  end

  // stage 4: determinant, magnitudes, signs
  logic signed [50:0]   det;
  logic [50:0]          det_abs;
  m3it_pkg::lane_in_t   lane_in [9];
  logic [32:0]          cabs [9];

  always_comb begin
    det     = 51'(dp[0]) + 51'(dp[1]) + 51'(dp[2]);
    det_abs = det[50] ? 51'(-det) : 51'(det);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        lane_in[k].c_mag <= cabs[k][31:0];
        lane_in[k].den   <= det_abs[47:0];
        lane_in[k].neg   <= cof3[k][32] ^ det[50];
        lane_in[k].zero  <= det == '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cabs[k] = cof3[k][32] ? 33'(-cof3[k]) : 33'(cof3[k]);
    end
  end

  // divider lanes
  m3it_pkg::lane_out_t lane_out [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3it_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .din  (lane_in[k]),
      .dout (lane_out[k])
    );
  end

  logic any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      any_sat = any_sat | lane_out[k].sat;
    end
  end

  assign res.valid  = vld[Lat-1];
  assign res.r00    = lane_out[0].res;
  assign res.r01    = lane_out[1].res;
  assign res.r02    = lane_out[2].res;
  assign res.r10    = lane_out[3].res;
  assign res.r11    = lane_out[4].res;
  assign res.r12    = lane_out[5].res;
  assign res.r20    = lane_out[6].res;
  assign res.r21    = lane_out[7].res;
  assign res.r22    = lane_out[8].res;
  assign res.status = lane_out[0].zero ? m3it_pkg::STATUS_SINGULAR :
                      any_sat          ? m3it_pkg::STATUS_OVERFLOW :
                                         m3it_pkg::STATUS_OK;

  // checks
  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !mat.ready)
    else $error("input taken while output stalled");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == m3it_pkg::STATUS_SINGULAR) |->
      (res.r00 == 0 && res.r11 == 0 && res.r22 == 0 && res.r01 == 0))
    else $error("singular result not zeroed");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.r00) && $stable(res.status)))
    else $error("stalled result changed");

endmodule
